FILE: hdl/bsc_pkg.sv
`timescale 1ns / 1ps
package bsc_pkg;

	localparam int unsigned CalW = 48;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned DivSteps = 32;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegTempCal = 3'd0;
	localparam logic [CfgIdxW-1:0] RegPressA = 3'd1;
	localparam logic [CfgIdxW-1:0] RegPressB = 3'd2;
	localparam logic [CfgIdxW-1:0] RegPressC = 3'd3;

	localparam logic [31:0] PressOffset = 32'd64000;
	localparam logic [31:0] RawPressBase = 32'd1048576;
	localparam logic [31:0] PressScale = 32'd3125;
	localparam logic [31:0] RoundHalf = 32'd128;
	localparam logic [31:0] OneQ15 = 32'd32768;

	// calibration words, already extended to 32 bits
	typedef struct packed {
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] t3;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] p3;
		logic [31:0] p4;
		logic [31:0] p5;
		logic [31:0] p6;
		logic [31:0] p7;
		logic [31:0] p8;
		logic [31:0] p9;
	} cal_t;

	// fields that ride alongside the divider
	typedef struct packed {
		logic [31:0] temp;
		logic        inv;
		logic        big;
	} side_t;

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p[31:0];
	endfunction

	function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] w);
		return {{16{w[15]}}, w};
	endfunction

endpackage

FILE: hdl/barometric_sensor_compensation.sv
// an accepted request passes through the front stages, the divider and the back stages to its result
// throughput: one request per cycle while no result is stalled; the 32-stage divider is one quotient bit a stage
// a stalled result holds the whole pipeline until it is taken
// reset (arst_n low) empties the pipeline and clears all calibration words to zero
// configuration writes are always accepted
`timescale 1ns / 1ps
module barometric_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] temperature_centi,
	output logic [31:0] pressure_pascal,
	output logic        pressure_invalid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [bsc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bsc_pkg::CalW-1:0] cfg_data
);

	logic [bsc_pkg::CalW-1:0] tcal_q, pa_q, pb_q, pc_q;
	bsc_pkg::cal_t cal;
	logic adv;
	logic f_v, d_v;
	logic [31:0] f_div, f_num, f_temp, d_quot, b_temp;
	bsc_pkg::side_t d_side;

	assign cfg_ready = 1'b1;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q <= '0;
			pa_q <= '0;
			pb_q <= '0;
			pc_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bsc_pkg::RegTempCal: tcal_q <= cfg_data;
				bsc_pkg::RegPressA: pa_q <= cfg_data;
				bsc_pkg::RegPressB: pb_q <= cfg_data;
				bsc_pkg::RegPressC: pc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack the calibration words
	always_comb begin
		cal.t1 = {16'd0, tcal_q[15:0]};
		cal.t2 = bsc_pkg::sx16(tcal_q[31:16]);
		cal.t3 = bsc_pkg::sx16(tcal_q[47:32]);
		cal.p1 = {16'd0, pa_q[15:0]};
		cal.p2 = bsc_pkg::sx16(pa_q[31:16]);
		cal.p3 = bsc_pkg::sx16(pa_q[47:32]);
		cal.p4 = bsc_pkg::sx16(pb_q[15:0]);
		cal.p5 = bsc_pkg::sx16(pb_q[31:16]);
		cal.p6 = bsc_pkg::sx16(pb_q[47:32]);
		cal.p7 = bsc_pkg::sx16(pc_q[15:0]);
		cal.p8 = bsc_pkg::sx16(pc_q[31:16]);
		cal.p9 = bsc_pkg::sx16(pc_q[47:32]);
	end

	bsc_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(in_valid && adv),
		.raw_t(raw_temperature), .raw_p(raw_pressure), .cal(cal),
		.vout(f_v), .divisor(f_div), .dividend(f_num), .temp(f_temp)
	);

	bsc_div u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(f_v),
		.divisor(f_div), .dividend(f_num), .temp(f_temp),
		.vout(d_v), .quot(d_quot), .side(d_side)
	);

	bsc_back u_back (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(d_v),
		.quot(d_quot), .side(d_side), .cal(cal),
		.vout(out_valid), .temp(b_temp), .press(pressure_pascal), .inv(pressure_invalid)
	);

	assign temperature_centi = $signed(b_temp);

endmodule

FILE: hdl/bsc_front.sv
`timescale 1ns / 1ps
module bsc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vin,
	input  logic [19:0]         raw_t,
	input  logic [19:0]         raw_p,
	input  bsc_pkg::cal_t       cal,
	output logic                vout,
	output logic [31:0]         divisor,
	output logic [31:0]         dividend,
	output logic [31:0]         temp
);

	logic [7:0] v_q;
	logic [31:0] adc_t, adc_p, d, fine;
	logic [31:0] m1_s1, dd_s1, adcp_s1;
	logic [31:0] a_s2, mt3_s2, adcp_s2;
	logic [31:0] temp_s3, pa_s3, adcp_s3;
	logic [31:0] sq_s4, m5_s4, m2_s4, temp_s4, adcp_s4;
	logic [31:0] b6_s5, m3_s5, m5_s5, m2_s5, temp_s5, adcp_s5;
	logic [31:0] bb_s6, ap_s6, temp_s6, adcp_s6;
	logic [31:0] a2_s7, pv_s7, temp_s7;
	logic [31:0] div_s8, pm_s8, temp_s8;

	assign adc_t = {12'd0, raw_t};
	assign adc_p = {12'd0, raw_p};
	assign d = (adc_t >> 4) - cal.t1;
	assign fine = a_s2 + bsc_pkg::sra(mt3_s2, 14);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[6:0], vin};
		end
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s1 <= bsc_pkg::mul32((adc_t >> 3) - (cal.t1 << 1), cal.t2);
			dd_s1 <= bsc_pkg::mul32(d, d);
			adcp_s1 <= adc_p;

			a_s2 <= bsc_pkg::sra(m1_s1, 11);
			mt3_s2 <= bsc_pkg::mul32(bsc_pkg::sra(dd_s1, 12), cal.t3);
			adcp_s2 <= adcp_s1;

			temp_s3 <= bsc_pkg::sra((fine << 2) + fine + bsc_pkg::RoundHalf, 8);
			pa_s3 <= bsc_pkg::sra(fine, 1) - bsc_pkg::PressOffset;
			adcp_s3 <= adcp_s2;

			sq_s4 <= bsc_pkg::mul32(bsc_pkg::sra(pa_s3, 2), bsc_pkg::sra(pa_s3, 2));
			m5_s4 <= bsc_pkg::mul32(pa_s3, cal.p5);
			m2_s4 <= bsc_pkg::mul32(cal.p2, pa_s3);
			temp_s4 <= temp_s3;
			adcp_s4 <= adcp_s3;

			b6_s5 <= bsc_pkg::mul32(bsc_pkg::sra(sq_s4, 11), cal.p6);
			m3_s5 <= bsc_pkg::mul32(cal.p3, bsc_pkg::sra(sq_s4, 13));
			m5_s5 <= m5_s4;
			m2_s5 <= m2_s4;
			temp_s5 <= temp_s4;
			adcp_s5 <= adcp_s4;

			bb_s6 <= bsc_pkg::sra(b6_s5 + (m5_s5 << 1), 2) + (cal.p4 << 16);
			ap_s6 <= bsc_pkg::OneQ15 + bsc_pkg::sra(bsc_pkg::sra(m3_s5, 3)
				+ bsc_pkg::sra(m2_s5, 1), 18);
			temp_s6 <= temp_s5;
			adcp_s6 <= adcp_s5;

			a2_s7 <= bsc_pkg::mul32(ap_s6, cal.p1);
			pv_s7 <= (bsc_pkg::RawPressBase - adcp_s6) - bsc_pkg::sra(bb_s6, 12);
			temp_s7 <= temp_s6;

			div_s8 <= bsc_pkg::sra(a2_s7, 15);
			pm_s8 <= bsc_pkg::mul32(pv_s7, bsc_pkg::PressScale);
			temp_s8 <= temp_s7;
		end
	end

	assign vout = v_q[7];
	assign divisor = div_s8;
	assign dividend = pm_s8;
	assign temp = temp_s8;

endmodule

FILE: hdl/bsc_div.sv
`timescale 1ns / 1ps
module bsc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vin,
	input  logic [31:0]         divisor,
	input  logic [31:0]         dividend,
	input  logic [31:0]         temp,
	output logic                vout,
	output logic [31:0]         quot,
	output bsc_pkg::side_t      side
);

	localparam int unsigned N = bsc_pkg::DivSteps;

	logic [N-1:0] v_q;
	logic [31:0] num_sx [1:N];
	logic [31:0] rem_sx [1:N];
	logic [31:0] den_sx [1:N];
	bsc_pkg::side_t side_sx [1:N];
	logic [31:0] num_in;
	bsc_pkg::side_t side_in;

	// stage zero inputs: a small dividend is doubled first, a large one is divided as is and its result doubled later
	always_comb begin
		num_in = dividend[31] ? dividend : {dividend[30:0], 1'b0};
		side_in.temp = temp;
		side_in.inv = (divisor == '0);
		side_in.big = dividend[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[N-2:0], vin};
		end
	end

	// one restoring step per stage
	for (genvar i = 0; i < N; i++) begin : g_step
		logic [31:0]    num_i;
		logic [31:0]    rem_i;
		logic [31:0]    den_i;
		bsc_pkg::side_t side_i;
		logic [32:0]    trial;
		logic           ge;
		if (i == 0) begin : g_first
			assign num_i = num_in;
			assign rem_i = '0;
			assign den_i = divisor;
			assign side_i = side_in;
		end else begin : g_next
			assign num_i = num_sx[i];
			assign rem_i = rem_sx[i];
			assign den_i = den_sx[i];
			assign side_i = side_sx[i];
		end
		assign trial = {rem_i, num_i[31]};
		assign ge = (trial >= {1'b0, den_i});
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sx[i+1] <= ge ? 32'(trial - {1'b0, den_i}) : trial[31:0];
				num_sx[i+1] <= {num_i[30:0], ge};
				den_sx[i+1] <= den_i;
				side_sx[i+1] <= side_i;
			end
		end
	end

	assign vout = v_q[N-1];
	assign quot = num_sx[N];
	assign side = side_sx[N];

endmodule

FILE: hdl/bsc_back.sv
`timescale 1ns / 1ps
module bsc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vin,
	input  logic [31:0]         quot,
	input  bsc_pkg::side_t      side,
	input  bsc_pkg::cal_t       cal,
	output logic                vout,
	output logic [31:0]         temp,
	output logic [31:0]         press,
	output logic                inv
);

	logic [2:0] v_q;
	logic [31:0] p;
	logic [31:0] p_s1, x_s1, m8_s1, temp_s1;
	logic inv_s1, inv_s2, inv_s3;
	logic [31:0] p_s2, a9_s2, b8_s2, temp_s2;
	logic [31:0] p_s3, temp_s3;

	assign p = side.big ? {quot[30:0], 1'b0} : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[1:0], vin};
		end
	end

	// second-order pressure correction, output register last
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= p;
			x_s1 <= bsc_pkg::mul32(p >> 3, p >> 3);
			m8_s1 <= bsc_pkg::mul32(p >> 2, cal.p8);
			temp_s1 <= side.temp;
			inv_s1 <= side.inv;

			p_s2 <= p_s1;
			a9_s2 <= bsc_pkg::sra(bsc_pkg::mul32(cal.p9, x_s1 >> 13), 12);
			b8_s2 <= bsc_pkg::sra(m8_s1, 13);
			temp_s2 <= temp_s1;
			inv_s2 <= inv_s1;

			p_s3 <= inv_s2 ? '0 : p_s2 + bsc_pkg::sra(a9_s2 + b8_s2 + cal.p7, 4);
			temp_s3 <= temp_s2;
			inv_s3 <= inv_s2;
		end
	end

	assign vout = v_q[2];
	assign temp = temp_s3;
	assign press = p_s3;
	assign inv = inv_s3;

endmodule

FILE: hdl/bsc_checker.sv
`timescale 1ns / 1ps
module bsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pressure_pascal,
	input logic        pressure_invalid,
	input logic        cfg_ready
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure_pascal))
		else $error("result dropped while stalled");

	// a zero divisor reports zero pressure
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressure_invalid |-> pressure_pascal == '0)
		else $error("invalid pressure not zero");

	// input side only stalls when a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input stalled without a waiting result");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration not accepted");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .pressure_pascal(pressure_pascal),
	.pressure_invalid(pressure_invalid), .cfg_ready(cfg_ready)
);

FILE: sim/tb_barometric_sensor_compensation.sv
`timescale 1ns / 1ps
module tb_barometric_sensor_compensation;

	typedef struct packed {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
	} reading_t;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] press;
		logic        inv;
	} comp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	logic        out_valid;
	logic        out_ready;
	logic signed [31:0] temperature_centi;
	logic [31:0] pressure_pascal;
	logic        pressure_invalid;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [bsc_pkg::CfgIdxW-1:0] cfg_index;
	logic [bsc_pkg::CalW-1:0] cfg_data;

	reading_t    pending_readings[$];
	comp_t       expected_comp[$];
	logic [bsc_pkg::CalW-1:0] cal_copy[4];
	int unsigned sent_count;
	int unsigned stall_left;
	bit          stalled_once;
	bit          failed;

	barometric_sensor_compensation i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.out_valid(out_valid), .out_ready(out_ready),
		.temperature_centi(temperature_centi), .pressure_pascal(pressure_pascal),
		.pressure_invalid(pressure_invalid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// arithmetic shift right on a 32-bit word
	function automatic logic [31:0] shr_s(input logic [31:0] x, input int unsigned n);
		logic signed [31:0] s;
		s = x;
		return s >>> n;
	endfunction

	// compensated temperature and pressure for one reading
	function automatic comp_t compensate(input reading_t r);
		logic [31:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] a, b, d, m, fine, q, sq, p, div;
		comp_t c;
		at = {12'd0, r.raw_t};
		ap = {12'd0, r.raw_p};
		t1 = {16'd0, cal_copy[bsc_pkg::RegTempCal][15:0]};
		t2 = 32'($signed(cal_copy[bsc_pkg::RegTempCal][31:16]));
		t3 = 32'($signed(cal_copy[bsc_pkg::RegTempCal][47:32]));
		p1 = {16'd0, cal_copy[bsc_pkg::RegPressA][15:0]};
		p2 = 32'($signed(cal_copy[bsc_pkg::RegPressA][31:16]));
		p3 = 32'($signed(cal_copy[bsc_pkg::RegPressA][47:32]));
		p4 = 32'($signed(cal_copy[bsc_pkg::RegPressB][15:0]));
		p5 = 32'($signed(cal_copy[bsc_pkg::RegPressB][31:16]));
		p6 = 32'($signed(cal_copy[bsc_pkg::RegPressB][47:32]));
		p7 = 32'($signed(cal_copy[bsc_pkg::RegPressC][15:0]));
		p8 = 32'($signed(cal_copy[bsc_pkg::RegPressC][31:16]));
		p9 = 32'($signed(cal_copy[bsc_pkg::RegPressC][47:32]));
		// temperature and fine temperature
		m = ((at >> 3) - (t1 << 1)) * t2;
		a = shr_s(m, 11);
		d = (at >> 4) - t1;
		m = shr_s(d * d, 12) * t3;
		b = shr_s(m, 14);
		fine = a + b;
		c.temp = shr_s(fine * 32'd5 + 32'd128, 8);
		// pressure terms
		a = shr_s(fine, 1) - 32'd64000;
		q = shr_s(a, 2);
		sq = q * q;
		b = shr_s(sq, 11) * p6;
		m = a * p5;
		b = b + (m << 1);
		b = shr_s(b, 2) + (p4 << 16);
		m = shr_s(p3 * shr_s(sq, 13), 3) + shr_s(p2 * a, 1);
		a = shr_s(m, 18);
		div = shr_s((32'd32768 + a) * p1, 15);
		c.inv = (div == 32'd0);
		c.press = 32'd0;
		if (!c.inv) begin
			p = ((32'd1048576 - ap) - shr_s(b, 12)) * 32'd3125;
			if (p < 32'h8000_0000)
				p = (p << 1) / div;
			else
				p = (p / div) * 32'd2;
			q = p >> 3;
			m = q * q;
			m = m >> 13;
			a = shr_s(p9 * m, 12);
			b = shr_s((p >> 2) * p8, 13);
			c.press = p + shr_s(a + b + p7, 4);
		end
		return c;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		reading_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			raw_temperature <= '0;
			raw_pressure <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				r.raw_t = raw_temperature;
				r.raw_p = raw_pressure;
				expected_comp.push_back(compensate(r));
				sent_count <= sent_count + 1;
			end
			if (pending_readings.size() != 0 &&
				((sent_count >= 30 && sent_count < 130) || $urandom_range(99) >= 32)) begin
				r = pending_readings.pop_front();
				in_valid <= 1'b1;
				raw_temperature <= r.raw_t;
				raw_pressure <= r.raw_p;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			stalled_once <= 1'b0;
		end else begin
			if (!stalled_once && sent_count >= 150) begin
				stalled_once <= 1'b1;
				stall_left <= 300;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (sent_count >= 30 && sent_count < 130) ||
					($urandom_range(99) >= 32);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		comp_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_comp.size() == 0) begin
				$display("%0t: unexpected result temp %0d press %0d inv %0b", $time,
					temperature_centi, pressure_pascal, pressure_invalid);
				failed = 1'b1;
			end else begin
				e = expected_comp.pop_front();
				if (temperature_centi !== e.temp) begin
					$display("%0t: temperature_centi expected %0d actual %0d", $time,
						$signed(e.temp), temperature_centi);
					failed = 1'b1;
				end
				if (pressure_pascal !== e.press) begin
					$display("%0t: pressure_pascal expected %0d actual %0d", $time,
						e.press, pressure_pascal);
					failed = 1'b1;
				end
				if (pressure_invalid !== e.inv) begin
					$display("%0t: pressure_invalid expected %0b actual %0b", $time,
						e.inv, pressure_invalid);
					failed = 1'b1;
				end
			end
		end
	end

	// calibration write, issued only while idle
	task automatic write_cal(input logic [bsc_pkg::CfgIdxW-1:0] idx,
		input logic [bsc_pkg::CalW-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx <= bsc_pkg::RegPressC)
			cal_copy[idx] = data;
	endtask

	task automatic write_all(input logic [bsc_pkg::CalW-1:0] t,
		input logic [bsc_pkg::CalW-1:0] pa,
		input logic [bsc_pkg::CalW-1:0] pb, input logic [bsc_pkg::CalW-1:0] pc);
		write_cal(bsc_pkg::RegTempCal, t);
		write_cal(bsc_pkg::RegPressA, pa);
		write_cal(bsc_pkg::RegPressB, pb);
		write_cal(bsc_pkg::RegPressC, pc);
	endtask

	task automatic queue_reading(input logic [19:0] t, input logic [19:0] p);
		reading_t r;
		r.raw_t = t;
		r.raw_p = p;
		pending_readings.push_back(r);
	endtask

	// mostly plausible readings, some anywhere in range
	task automatic queue_random(input int unsigned n);
		repeat (n) begin
			if ($urandom_range(99) < 70)
				queue_reading(20'($urandom_range(600000, 400000)),
					20'($urandom_range(700000, 200000)));
			else
				queue_reading(20'($urandom), 20'($urandom));
		end
	endtask

	// wait until everything queued has come back, then let the pipe drain
	task automatic drain;
		while (pending_readings.size() != 0 || in_valid || expected_comp.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// stimulus
	initial begin
		failed = 1'b0;
		sent_count = 0;
		foreach (cal_copy[i]) cal_copy[i] = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// uncalibrated: every reading reports the zero divisor
		queue_reading(20'd0, 20'd0);
		queue_reading(20'hFFFFF, 20'hFFFFF);
		queue_reading(20'h55555, 20'hAAAAA);
		drain();

		// typical calibration, field extremes then random readings
		write_all({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
			{16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
		queue_reading(20'd0, 20'd0);
		queue_reading(20'hFFFFF, 20'd0);
		queue_reading(20'd0, 20'hFFFFF);
		queue_reading(20'hFFFFF, 20'hFFFFF);
		queue_reading(20'd519888, 20'd415148);
		queue_reading(20'hAAAAA, 20'h55555);
		queue_random(250);
		drain();

		// all-ones words, two ignored out-of-range writes, then a zero P1
		write_all({bsc_pkg::CalW{1'b1}}, {bsc_pkg::CalW{1'b1}}, {bsc_pkg::CalW{1'b1}},
			{bsc_pkg::CalW{1'b1}});
		write_cal(3'd4, '0);
		write_cal(3'd7, '0);
		queue_reading(20'd0, 20'd0);
		queue_reading(20'hFFFFF, 20'hFFFFF);
		queue_random(40);
		drain();
		write_cal(bsc_pkg::RegPressA, {16'd3024, 16'hD643, 16'd0});
		queue_random(20);
		drain();

		// random calibration sets
		repeat (4) begin
			write_all(bsc_pkg::CalW'({$urandom, $urandom}),
				bsc_pkg::CalW'({$urandom, $urandom}),
				bsc_pkg::CalW'({$urandom, $urandom}),
				bsc_pkg::CalW'({$urandom, $urandom}));
			queue_random(50);
			drain();
		end

		if (!failed)
			$display("tb_barometric_sensor_compensation: PASS");
		else
			$display("tb_barometric_sensor_compensation: FAIL");
		$finish;
	end

	// timeout
	initial begin
		#5ms;
		$display("tb_barometric_sensor_compensation: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
hdl/bsc_pkg.sv
hdl/bsc_front.sv
hdl/bsc_div.sv
hdl/bsc_back.sv
hdl/barometric_sensor_compensation.sv
hdl/bsc_checker.sv
sim/tb_barometric_sensor_compensation.sv
